// File: hdl/qsh_pkg.sv
// ----------------------------------------------------------------------------
// qsh_pkg
// Types and constants shared by the quicksort batch sorter.
// ----------------------------------------------------------------------------
package qsh_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned CntW        = 20;
  localparam logic [CntW-1:0] CntMax  = '1;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               is_last_res;
    logic [CntW-1:0]    comparison_count;
    logic [CntW-1:0]    memory_access_count;
  } out_item_t;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] c,
                                              input logic [2:0] n);
    logic [CntW:0] s;
    s = {1'b0, c} + {{(CntW-2){1'b0}}, n};
    return s[CntW] ? CntMax : s[CntW-1:0];
  endfunction

endpackage

// File: hdl/quicksort_hoare_counting.sv
// ----------------------------------------------------------------------------
// quicksort_hoare_counting
// Batch sorter: loads signed values until a last mark or a full store, sorts them with
// quicksort (Hoare partition, middle pivot, explicit range stack) and emits
// them ascending with comparison and access counts.
// ----------------------------------------------------------------------------
// Loading takes in a transfer whenever the input is valid. After the last item,
// or when the store holds MAX_ELEMENTS, the block stalls input and sorts in
// place. It uses a single-port element RAM and a single-port range-stack RAM.
// Both RAMs have a registered read, so each scan test has a read state and a
// compare state, and a swap adds a second write state. Every range also passes
// through stack pop and read, pivot read and wait, and two pushes. The sort time
// is therefore set mainly by the comparison count. A single-element batch skips
// the sort. Results then leave through an output register, each with an address
// state and an output state, and wait while the output stalls. Input reopens as
// soon as the final result sits in the output register.
module quicksort_hoare_counting
  import qsh_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = qsh_pkg::MaxElements
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qsh_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qsh_pkg::out_item_t out_data_o
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned NW = IW + 1;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_POP   = 14'b00000000000010,
    S_PIVA  = 14'b00000000000100,
    S_PIVW  = 14'b00000000001000,
    S_LRD   = 14'b00000000010000,
    S_LCMP  = 14'b00000000100000,
    S_HRD   = 14'b00000001000000,
    S_HCMP  = 14'b00000010000000,
    S_POPRD = 14'b00000100000000,
    S_SWH   = 14'b00001000000000,
    S_PUSH1 = 14'b00010000000000,
    S_PUSH2 = 14'b00100000000000,
    S_ORD   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d, k_q, k_d;
  logic [NW-1:0] sp_q, sp_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, l_q, l_d, h_q, h_d;
  logic signed [31:0] piv_q, piv_d, lv_q, lv_d;
  logic [CntW-1:0] cmp_q, cmp_d, acc_q, acc_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic            stk_we;
  logic [IW-1:0]   stk_wlo, stk_whi, stk_addr;
  logic [2*IW-1:0] stk_rdata;
  logic [IW-1:0]   j;

  qsh_ram #(.Width(32), .Depth(MAX_ELEMENTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Range stack: lo in the upper half, hi in the lower half.
  qsh_ram #(.Width(2 * IW), .Depth(MAX_ELEMENTS)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we && (sp_q < NW'(MAX_ELEMENTS))),
    .addr_i (stk_addr),
    .wdata_i({stk_wlo, stk_whi}),
    .rdata_o(stk_rdata)
  );

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; k_d = k_q; sp_d = sp_q;
    lo_d = lo_q; hi_d = hi_q; l_d = l_q; h_d = h_q;
    piv_d = piv_q; lv_d = lv_q; cmp_d = cmp_q; acc_d = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    ram_we = 1'b0; ram_addr = l_q; ram_wdata = lv_q;
    stk_we = 1'b0; stk_wlo = lo_q; stk_whi = hi_q; stk_addr = sp_q[IW-1:0];
    j = h_q;
    if (h_q >= hi_q) j = hi_q - 1'b1;
    if (j < lo_q) j = lo_q;
    case (state_q)
      S_LOAD: begin
        ram_addr = cnt_q[IW-1:0];
        ram_wdata = in_data_i.value;
        if (in_valid_i) begin
          ram_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (in_data_i.is_last || cnt_d == NW'(MAX_ELEMENTS)) begin
            cmp_d = '0; acc_d = '0; sp_d = '0; k_d = '0;
            if (cnt_d == NW'(1)) begin
              state_d = S_ORD;
            end else begin
              stk_we = 1'b1; stk_wlo = '0; stk_whi = IW'(cnt_q);
              sp_d = NW'(1);
              state_d = S_POP;
            end
          end
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          state_d = S_ORD;
        end else begin
          sp_d = sp_q - 1'b1;
          stk_addr = sp_d[IW-1:0];
          state_d = S_POPRD;
        end
      end
      S_POPRD: begin
        lo_d = stk_rdata[2*IW-1:IW];
        hi_d = stk_rdata[IW-1:0];
        l_d = lo_d; h_d = hi_d;
        state_d = (lo_d >= hi_d) ? S_POP : S_PIVA;
      end
      S_PIVA: begin
        ram_addr = lo_q + IW'((hi_q - lo_q) >> 1);
        acc_d = sat_add(acc_q, 3'd1);
        state_d = S_PIVW;
      end
      S_PIVW: begin
        piv_d = ram_rdata;
        state_d = S_LRD;
      end
      S_LRD: begin
        ram_addr = l_q;
        state_d = S_LCMP;
      end
      S_LCMP: begin
        acc_d = sat_add(acc_q, 3'd1); cmp_d = sat_add(cmp_q, 3'd1);
        lv_d = ram_rdata;
        if ($signed(ram_rdata) < piv_q) begin
          l_d = l_q + 1'b1; state_d = S_LRD;
        end else begin
          state_d = S_HRD;
        end
      end
      S_HRD: begin
        ram_addr = h_q;
        state_d = S_HCMP;
      end
      S_HCMP: begin
        acc_d = sat_add(acc_q, 3'd1); cmp_d = sat_add(cmp_q, 3'd1);
        if (piv_q < $signed(ram_rdata)) begin
          h_d = h_q - 1'b1; state_d = S_HRD;
        end else if (l_q >= h_q) begin
          state_d = S_PUSH1;
        end else begin
          piv_d = piv_q;
          ram_we = 1'b1; ram_addr = l_q; ram_wdata = ram_rdata;
          state_d = S_SWH;
        end
      end
      S_SWH: begin
        ram_we = 1'b1; ram_addr = h_q; ram_wdata = lv_q;
        acc_d = sat_add(acc_q, 3'd4);
        l_d = l_q + 1'b1; h_d = h_q - 1'b1;
        state_d = S_LRD;
      end
      S_PUSH1: begin
        if (j + 1'b1 < hi_q) begin
          stk_we = 1'b1; stk_wlo = j + 1'b1; stk_whi = hi_q;
          if (sp_q < NW'(MAX_ELEMENTS)) sp_d = sp_q + 1'b1;
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (lo_q < j) begin
          stk_we = 1'b1; stk_wlo = lo_q; stk_whi = j;
          if (sp_q < NW'(MAX_ELEMENTS)) sp_d = sp_q + 1'b1;
        end
        state_d = S_POP;
      end
      S_ORD: begin
        ram_addr = k_q[IW-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        ram_addr = k_q[IW-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.value_res = ram_rdata;
          out_d.is_last_res = (k_q + 1'b1 == cnt_q);
          out_d.comparison_count = cmp_q;
          out_d.memory_access_count = acc_q;
          k_d = k_q + 1'b1;
          if (k_d == cnt_q) begin
            cnt_d = '0; state_d = S_LOAD;
          end else begin
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; k_q <= '0; sp_q <= '0;
      cmp_q <= '0; acc_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; k_q <= k_d; sp_q <= sp_d;
      cmp_q <= cmp_d; acc_q <= acc_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; l_q <= l_d; h_q <= h_d;
    piv_q <= piv_d; lv_q <= lv_d; out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/qsh_ram.sv
// ----------------------------------------------------------------------------
// qsh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qsh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hdl/qsh_checker.sv
// ----------------------------------------------------------------------------
// qsh_checker
// Port-level checks for the quicksort batch sorter.
// ----------------------------------------------------------------------------
module qsh_checker
  import qsh_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input qsh_pkg::out_item_t out_data_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input stays closed while a result other than the final one is pending
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_last_res |-> in_stall_o)
    else $error("input opened mid batch");

  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.is_last_res ##1 out_valid_o
    |-> out_data_o.comparison_count == $past(out_data_o.comparison_count))
    else $error("count changed within batch");

  a_cmp_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.comparison_count <= out_data_o.memory_access_count)
    else $error("comparisons exceed accesses");

endmodule

bind quicksort_hoare_counting qsh_checker u_qsh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_data_o (out_data_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);
